>>> design/opl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opl_pkg
// Shared types, codes and defaults for the ordered pair list table.
// ----------------------------------------------------------------------------
package opl_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int FIRST_WIDTH_DEF  = 32;
    localparam int SECOND_WIDTH_DEF = 32;

    // longest run of pairs one list_unique transaction may emit
    localparam int MAX_RUN          = 16;

    // port field widths
    localparam int ACTION_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int SPAN_W      = 5;
    localparam int STATUS_W    = 2;
    localparam int INDEX_W     = 4;
    localparam int ENTRIES_W   = 5;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 80;
    localparam int S_TUSER_W   = 3;
    localparam int M_TUSER_W   = 3;
    localparam int MAX_VALUE_W = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND         = 3'd0,
        ACT_REMOVE_AT      = 3'd1,
        ACT_REMOVE_COUNT   = 3'd2,
        ACT_REMOVE_THROUGH = 3'd3,
        ACT_FIND           = 3'd4,
        ACT_LIST_UNIQUE    = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   found_index;
        logic [VALUE_W-1:0]   pair_first;
        logic [VALUE_W-1:0]   pair_second;
        logic                 has_pair;
        logic                 last;
        logic [ENTRIES_W-1:0] entries_now;
    } t_result;

endpackage

>>> design/opl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module opl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ordered_pair_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_pair_list_table
// Ordered list of pairs with append, removal, span removal, find and unique
// listing, run by a small sequencer around one pair RAM.
// ----------------------------------------------------------------------------
// find reads the entries in turn until a match or the end of the list; remove_at
// moves each tail entry down in turn before its result; span removals emit the
// removed pairs one per cycle while the output is not stalled, then move the
// tail down before the next input; list_unique compares each entry with every
// earlier one, all through the single RAM read port. one item at a time: not
// ready until done.
// reset clears the state, the entry count and the output and pending valid
// flags; the pair RAM is not cleared and no clearing pass is run.
module ordered_pair_list_table #(
    parameter int CAPACITY     = opl_pkg::CAPACITY_DEF,
    parameter int FIRST_WIDTH  = opl_pkg::FIRST_WIDTH_DEF,
    parameter int SECOND_WIDTH = opl_pkg::SECOND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // first_value, second_value, position, span_count, last_position, zero pad
    input  logic [opl_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // action
    input  logic [opl_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // found_index, pair_first, pair_second, entries_now, zero pad
    output logic [opl_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // status, has_pair
    output logic [opl_pkg::M_TUSER_W-1:0]   o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = ((CW > 6) ? CW : 6) + 1;
    localparam int DW = FIRST_WIDTH + SECOND_WIDTH;
    localparam int VW = opl_pkg::VALUE_W;
    localparam int KW = $clog2(opl_pkg::MAX_RUN + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RESULT,
        S_EM,
        S_SH,
        S_FD,
        S_UQ_LD,
        S_UQ_CMP,
        S_UQ_EM,
        S_UQ_NX,
        S_UQ_FIN
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    opl_pkg::t_action                r_action, n_action;
    logic [FIRST_WIDTH-1:0]          r_a, n_a;
    logic [SECOND_WIDTH-1:0]         r_b, n_b;
    logic [opl_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [opl_pkg::SPAN_W-1:0]      r_cnt, n_cnt;
    logic [opl_pkg::POS_W-1:0]       r_lastp, n_lastp;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_jdx, n_jdx;
    logic [CW-1:0]                   r_end, n_end;
    logic [CW-1:0]                   r_n, n_n;
    logic [CW-1:0]                   r_limit, n_limit;
    logic [IW-1:0]                   r_addr, n_addr;
    logic                            r_emitted, n_emitted;
    opl_pkg::t_status                r_res_status, n_res_status;
    logic [CW-1:0]                   r_res_idx, n_res_idx;
    logic [DW-1:0]                   r_hold, n_hold;
    logic [DW-1:0]                   r_pend, n_pend;
    logic                            r_pend_valid, n_pend_valid;
    logic [KW-1:0]                   r_k, n_k;
    logic                            r_out_valid, n_out_valid;
    opl_pkg::t_result                r_out, n_out;

    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    logic [DW-1:0]                   wr_data;
    logic [DW-1:0]                   rd_data;
    logic                            out_free;
    logic                            s_accept;
    logic [AW-1:0]                   pos_w, cnt_w, lastp_w, count_w, span_n;

    function automatic opl_pkg::t_result make_result(
        input opl_pkg::t_status st,
        input logic [CW-1:0]    idx,
        input logic [DW-1:0]    pair,
        input logic             has,
        input logic             last,
        input logic [CW-1:0]    entries
    );
        opl_pkg::t_result              res;
        logic [AW-1:0]                 idx_w;
        logic [AW-1:0]                 ent_w;
        logic [opl_pkg::MAX_VALUE_W-1:0] f_w;
        logic [opl_pkg::MAX_VALUE_W-1:0] s_w;
        idx_w = AW'(idx);
        ent_w = AW'(entries);
        f_w   = opl_pkg::MAX_VALUE_W'(pair[FIRST_WIDTH-1:0]);
        s_w   = opl_pkg::MAX_VALUE_W'(pair[DW-1:FIRST_WIDTH]);
        res.status      = st;
        res.found_index = idx_w[opl_pkg::INDEX_W-1:0];
        res.pair_first  = has ? f_w[VW-1:0] : '0;
        res.pair_second = has ? s_w[VW-1:0] : '0;
        res.has_pair    = has;
        res.last        = last;
        res.entries_now = ent_w[opl_pkg::ENTRIES_W-1:0];
        return res;
    endfunction

    opl_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_pair_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign pos_w   = AW'(r_pos);
    assign cnt_w   = AW'(r_cnt);
    assign lastp_w = AW'(r_lastp);
    assign count_w = AW'(r_count);
    assign span_n  = (r_action == opl_pkg::ACT_REMOVE_THROUGH) ?
                     AW'(lastp_w - pos_w + AW'(1)) : cnt_w;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_action     = r_action;
        n_a          = r_a;
        n_b          = r_b;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_lastp      = r_lastp;
        n_idx        = r_idx;
        n_jdx        = r_jdx;
        n_end        = r_end;
        n_n          = r_n;
        n_limit      = r_limit;
        n_addr       = r_addr;
        n_emitted    = r_emitted;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_hold       = r_hold;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out        = r_out;
        wr_en        = 1'b0;
        wr_addr      = r_count[IW-1:0];
        wr_data      = {r_b, r_a};

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_action = opl_pkg::t_action'(i_s_axis_tuser[opl_pkg::ACTION_W-1:0]);
                    n_a      = FIRST_WIDTH'(i_s_axis_tdata[31:0]);
                    n_b      = SECOND_WIDTH'(i_s_axis_tdata[63:32]);
                    n_pos    = i_s_axis_tdata[67:64];
                    n_cnt    = i_s_axis_tdata[72:68];
                    n_lastp  = i_s_axis_tdata[76:73];
                    n_state  = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_res_status = opl_pkg::ST_OK;
                n_res_idx    = '0;
                n_state      = S_RESULT;
                case (r_action)
                    opl_pkg::ACT_APPEND: begin
                        if (count_w >= AW'(CAPACITY)) begin
                            n_res_status = opl_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = CW'(r_count + 1'b1);
                        end
                    end
                    opl_pkg::ACT_REMOVE_AT: begin
                        if (pos_w >= count_w) begin
                            n_res_status = opl_pkg::ST_BAD;
                        end else begin
                            n_count   = CW'(r_count - 1'b1);
                            n_limit   = r_count;
                            n_n       = CW'(1);
                            n_idx     = CW'(pos_w + AW'(1));
                            n_addr    = IW'(pos_w + AW'(1));
                            n_emitted = 1'b0;
                            n_state   = S_SH;
                        end
                    end
                    opl_pkg::ACT_REMOVE_COUNT, opl_pkg::ACT_REMOVE_THROUGH: begin
                        if ((r_action == opl_pkg::ACT_REMOVE_COUNT &&
                             (cnt_w > AW'(opl_pkg::MAX_RUN) ||
                              AW'(pos_w + cnt_w) > count_w)) ||
                            (r_action == opl_pkg::ACT_REMOVE_THROUGH &&
                             (pos_w > lastp_w || lastp_w >= count_w))) begin
                            n_res_status = opl_pkg::ST_BAD;
                        end else if (span_n != '0) begin
                            n_count   = CW'(count_w - span_n);
                            n_limit   = r_count;
                            n_n       = CW'(span_n);
                            n_idx     = CW'(pos_w);
                            n_end     = CW'(pos_w + span_n - AW'(1));
                            n_addr    = IW'(pos_w);
                            n_emitted = 1'b1;
                            n_state   = S_EM;
                        end
                    end
                    opl_pkg::ACT_FIND: begin
                        n_idx   = '0;
                        n_addr  = '0;
                        n_state = S_FD;
                    end
                    opl_pkg::ACT_LIST_UNIQUE: begin
                        if (r_count != '0) begin
                            n_idx        = '0;
                            n_addr       = '0;
                            n_k          = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_UQ_LD;
                        end
                    end
                    default: begin
                        n_res_status = opl_pkg::ST_BAD;
                    end
                endcase
            end

            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = make_result(r_res_status, r_res_idx, '0, 1'b0, 1'b1, r_count);
                    n_state = S_IDLE;
                end
            end

            // emit the removed span one pair per transaction
            S_EM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = make_result(opl_pkg::ST_OK, '0, rd_data, 1'b1,
                                        r_idx == r_end, r_count);
                    n_idx  = CW'(r_idx + 1'b1);
                    n_addr = IW'(r_idx + 1'b1);
                    if (r_idx == r_end) begin
                        n_state = S_SH;
                    end
                end
            end

            // move the tail down by the span length
            S_SH: begin
                if (r_idx >= r_limit) begin
                    n_res_status = opl_pkg::ST_OK;
                    n_res_idx    = '0;
                    n_state      = r_emitted ? S_IDLE : S_RESULT;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(r_idx - r_n);
                    wr_data = rd_data;
                    n_idx   = CW'(r_idx + 1'b1);
                    n_addr  = IW'(r_idx + 1'b1);
                end
            end

            S_FD: begin
                if (r_idx >= r_count) begin
                    n_res_status = opl_pkg::ST_NOT_FOUND;
                    n_res_idx    = '0;
                    n_state      = S_RESULT;
                end else if (rd_data == {r_b, r_a}) begin
                    n_res_status = opl_pkg::ST_OK;
                    n_res_idx    = r_idx;
                    n_state      = S_RESULT;
                end else begin
                    n_idx  = CW'(r_idx + 1'b1);
                    n_addr = IW'(r_idx + 1'b1);
                end
            end

            S_UQ_LD: begin
                n_hold = rd_data;
                if (r_idx == '0) begin
                    n_state = S_UQ_EM;
                end else begin
                    n_jdx   = '0;
                    n_addr  = '0;
                    n_state = S_UQ_CMP;
                end
            end

            // compare held entry against each earlier one
            S_UQ_CMP: begin
                if (rd_data == r_hold) begin
                    n_state = S_UQ_NX;
                end else if (CW'(r_jdx + 1'b1) == r_idx) begin
                    n_state = S_UQ_EM;
                end else begin
                    n_jdx  = CW'(r_jdx + 1'b1);
                    n_addr = IW'(r_jdx + 1'b1);
                end
            end

            // one pair is kept back so the final one can carry tlast
            S_UQ_EM: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out = make_result(opl_pkg::ST_OK, '0, r_pend, 1'b1, 1'b0,
                                            r_count);
                    end
                    n_pend       = r_hold;
                    n_pend_valid = 1'b1;
                    n_k          = KW'(r_k + 1'b1);
                    n_state      = (KW'(r_k + 1'b1) == KW'(opl_pkg::MAX_RUN)) ?
                                   S_UQ_FIN : S_UQ_NX;
                end
            end

            S_UQ_NX: begin
                if (CW'(r_idx + 1'b1) >= r_count) begin
                    n_state = S_UQ_FIN;
                end else begin
                    n_idx   = CW'(r_idx + 1'b1);
                    n_addr  = IW'(r_idx + 1'b1);
                    n_state = S_UQ_LD;
                end
            end

            S_UQ_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out = make_result(opl_pkg::ST_OK, '0, r_pend, 1'b1, 1'b1, r_count);
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
        r_action     <= n_action;
        r_a          <= n_a;
        r_b          <= n_b;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_lastp      <= n_lastp;
        r_idx        <= n_idx;
        r_jdx        <= n_jdx;
        r_end        <= n_end;
        r_n          <= n_n;
        r_limit      <= n_limit;
        r_addr       <= n_addr;
        r_emitted    <= n_emitted;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_hold       <= n_hold;
        r_pend       <= n_pend;
        r_k          <= n_k;
        r_out        <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tuser  = {r_out.has_pair, r_out.status};
    assign o_m_axis_tdata  = {7'd0, r_out.entries_now, r_out.pair_second,
                              r_out.pair_first, r_out.found_index};

endmodule

>>> test/ordered_pair_list_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_pair_list_table_tb
// Self-checking bench for the pair list. A short table of directed actions
// covers the empty list, the value extremes, the bad and not-found codes and
// the unused action codes. Random action sequences then fill, search, list and
// drain the list, with random stalls on both stream sides. Every result is
// compared with the bench's own model of the list.
// ----------------------------------------------------------------------------
module ordered_pair_list_table_tb;

    localparam int ACTION_W     = opl_pkg::ACTION_W;
    localparam int VALUE_W      = opl_pkg::VALUE_W;
    localparam int POS_W        = opl_pkg::POS_W;
    localparam int SPAN_W       = opl_pkg::SPAN_W;
    localparam int INDEX_W      = opl_pkg::INDEX_W;
    localparam int ENTRIES_W    = opl_pkg::ENTRIES_W;
    localparam int S_TDATA_W    = opl_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = opl_pkg::M_TDATA_W;
    localparam int S_TUSER_W    = opl_pkg::S_TUSER_W;
    localparam int M_TUSER_W    = opl_pkg::M_TUSER_W;
    localparam int CAPACITY_DEF = opl_pkg::CAPACITY_DEF;
    localparam int MAX_RUN      = opl_pkg::MAX_RUN;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS = 170;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [ACTION_W-1:0]  act;
        logic [VALUE_W-1:0]   first_v;
        logic [VALUE_W-1:0]   second_v;
        logic [POS_W-1:0]     pos;
        logic [SPAN_W-1:0]    cnt;
        logic [POS_W-1:0]     lastp;
        logic                 typed;
        opl_pkg::t_status     st;
        logic [ENTRIES_W-1:0] entries;
    } t_step;

    // typed rows carry their single result; the others are checked against the list model
    localparam t_step DIRECTED [0:23] = '{
        '{opl_pkg::ACT_LIST_UNIQUE, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd0},
        '{opl_pkg::ACT_REMOVE_AT, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd0},
        '{opl_pkg::ACT_FIND, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_NOT_FOUND, 5'd0},
        '{opl_pkg::ACT_REMOVE_COUNT, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd0},
        '{opl_pkg::ACT_REMOVE_THROUGH, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd0},
        '{opl_pkg::ACT_APPEND, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd1},
        '{opl_pkg::ACT_APPEND, 32'hffffffff, 32'hffffffff, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd2},
        '{opl_pkg::ACT_APPEND, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd3},
        '{opl_pkg::ACT_APPEND, 32'h80000001, 32'h7ffffffe, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd4},
        '{opl_pkg::ACT_APPEND, 32'hffffffff, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd5},
        '{opl_pkg::ACT_LIST_UNIQUE, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b0, opl_pkg::ST_OK, 5'd0},
        '{opl_pkg::ACT_FIND, 32'hffffffff, 32'hffffffff, 4'd0, 5'd0, 4'd0,
          1'b0, opl_pkg::ST_OK, 5'd0},
        '{opl_pkg::ACT_FIND, 32'hffffffff, 32'hfffffffe, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_NOT_FOUND, 5'd5},
        '{opl_pkg::ACT_REMOVE_COUNT, 32'h0, 32'h0, 4'd1, 5'd31, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{opl_pkg::ACT_REMOVE_COUNT, 32'h0, 32'h0, 4'd15, 5'd16, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{opl_pkg::ACT_REMOVE_THROUGH, 32'h0, 32'h0, 4'd3, 5'd0, 4'd2,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{opl_pkg::ACT_REMOVE_THROUGH, 32'h0, 32'h0, 4'd0, 5'd0, 4'd15,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{opl_pkg::ACT_REMOVE_AT, 32'h0, 32'h0, 4'd15, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{ACT_SPARE_6, 32'h0, 32'h0, 4'd0, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{ACT_SPARE_7, 32'hffffffff, 32'hffffffff, 4'd15, 5'd31, 4'd15,
          1'b1, opl_pkg::ST_BAD, 5'd5},
        '{opl_pkg::ACT_REMOVE_COUNT, 32'h0, 32'h0, 4'd2, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd5},
        '{opl_pkg::ACT_REMOVE_THROUGH, 32'h0, 32'h0, 4'd1, 5'd0, 4'd2,
          1'b0, opl_pkg::ST_OK, 5'd0},
        '{opl_pkg::ACT_REMOVE_AT, 32'h0, 32'h0, 4'd2, 5'd0, 4'd0,
          1'b1, opl_pkg::ST_OK, 5'd2},
        '{opl_pkg::ACT_REMOVE_COUNT, 32'h0, 32'h0, 4'd0, 5'd2, 4'd0,
          1'b0, opl_pkg::ST_OK, 5'd0}
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // model of the stored list
    logic [VALUE_W-1:0] list_first  [CAPACITY_DEF];
    logic [VALUE_W-1:0] list_second [CAPACITY_DEF];
    int unsigned        list_len = 0;
    opl_pkg::t_result   pending_results [$];
    opl_pkg::t_result   step_run [$];

    bit calm_stretch = 1'b0;
    int actions_sent = 0;
    int results_seen = 0;
    int pairs_seen   = 0;
    int full_hits    = 0;
    int failures     = 0;

    ordered_pair_list_table u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= calm_stretch || ($urandom_range(0, 99) >= 36);
    end

    function automatic opl_pkg::t_result bare_result(opl_pkg::t_status st,
                                                     logic [INDEX_W-1:0] idx);
        opl_pkg::t_result r;
        r = '0;
        r.status      = st;
        r.found_index = idx;
        return r;
    endfunction

    // append to the results of the action being modeled
    function automatic void add_to_run(opl_pkg::t_result r);
        step_run.insert(step_run.size(), r);
    endfunction

    // append to the results the checker still waits for
    function automatic void queue_expected(opl_pkg::t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // applies one action to the list model and queues the results it causes
    function automatic void apply_action(logic [ACTION_W-1:0] act,
                                         logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                                         logic [POS_W-1:0] pos, logic [SPAN_W-1:0] cnt,
                                         logic [POS_W-1:0] lastp);
        opl_pkg::t_result r;
        int unsigned      p, c, lp, span_start, span_n, i, j;
        bit               dup;
        step_run.delete();
        p      = pos;
        c      = cnt;
        lp     = lastp;
        span_n = 0;
        span_start = 0;
        case (act)
            opl_pkg::ACT_APPEND: begin
                if (list_len >= CAPACITY_DEF) begin
                    add_to_run(bare_result(opl_pkg::ST_FULL, '0));
                    full_hits++;
                end else begin
                    list_first[list_len]  = a;
                    list_second[list_len] = b;
                    list_len++;
                    add_to_run(bare_result(opl_pkg::ST_OK, '0));
                end
            end
            opl_pkg::ACT_REMOVE_AT: begin
                if (p >= list_len) begin
                    add_to_run(bare_result(opl_pkg::ST_BAD, '0));
                end else begin
                    for (i = p; i + 1 < list_len; i++) begin
                        list_first[i]  = list_first[i + 1];
                        list_second[i] = list_second[i + 1];
                    end
                    list_len--;
                    add_to_run(bare_result(opl_pkg::ST_OK, '0));
                end
            end
            opl_pkg::ACT_REMOVE_COUNT: begin
                if (c > MAX_RUN || p + c > list_len) begin
                    add_to_run(bare_result(opl_pkg::ST_BAD, '0));
                end else if (c == 0) begin
                    add_to_run(bare_result(opl_pkg::ST_OK, '0));
                end else begin
                    span_start = p;
                    span_n     = c;
                end
            end
            opl_pkg::ACT_REMOVE_THROUGH: begin
                if (p > lp || lp >= list_len) begin
                    add_to_run(bare_result(opl_pkg::ST_BAD, '0));
                end else begin
                    span_start = p;
                    span_n     = lp - p + 1;
                end
            end
            opl_pkg::ACT_FIND: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_first[i] == a && list_second[i] == b) break;
                end
                if (i < list_len) add_to_run(bare_result(opl_pkg::ST_OK, INDEX_W'(i)));
                else add_to_run(bare_result(opl_pkg::ST_NOT_FOUND, '0));
            end
            opl_pkg::ACT_LIST_UNIQUE: begin
                for (i = 0; i < list_len && step_run.size() < MAX_RUN; i++) begin
                    dup = 1'b0;
                    for (j = 0; j < i; j++) begin
                        if (list_first[i] == list_first[j] &&
                            list_second[i] == list_second[j])
                            dup = 1'b1;
                    end
                    if (!dup) begin
                        r = bare_result(opl_pkg::ST_OK, '0);
                        r.pair_first  = list_first[i];
                        r.pair_second = list_second[i];
                        r.has_pair    = 1'b1;
                        add_to_run(r);
                    end
                end
                if (step_run.size() == 0) add_to_run(bare_result(opl_pkg::ST_OK, '0));
            end
            default: add_to_run(bare_result(opl_pkg::ST_BAD, '0));
        endcase
        if (span_n > 0) begin
            for (i = span_start; i < span_start + span_n; i++) begin
                r = bare_result(opl_pkg::ST_OK, '0);
                r.pair_first  = list_first[i];
                r.pair_second = list_second[i];
                r.has_pair    = 1'b1;
                add_to_run(r);
            end
            for (i = span_start + span_n; i < list_len; i++) begin
                list_first[i - span_n]  = list_first[i];
                list_second[i - span_n] = list_second[i];
            end
            list_len -= span_n;
        end
        foreach (step_run[k]) begin
            step_run[k].entries_now = ENTRIES_W'(list_len);
            step_run[k].last        = (k == step_run.size() - 1);
            queue_expected(step_run[k]);
        end
    endfunction

    // small values repeat often so that duplicates and find hits happen
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return VALUE_W'($urandom_range(0, 3));
        if (r < 45) return '1;
        if (r < 50) return {1'b1, {(VALUE_W-1){1'b0}}};
        return $urandom;
    endfunction

    task automatic send_action(input logic [ACTION_W-1:0] act,
                               input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                               input logic [POS_W-1:0] pos, input logic [SPAN_W-1:0] cnt,
                               input logic [POS_W-1:0] lastp);
        @(negedge clk);
        while (!calm_stretch && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, lastp, cnt, pos, b, a};
        do @(posedge clk); while (!s_tready);
        apply_action(act, a, b, pos, cnt, lastp);
        actions_sent++;
    endtask

    task automatic fill_list();
        while (list_len < CAPACITY_DEF)
            send_action(opl_pkg::ACT_APPEND, pick_value(), pick_value(),
                        $urandom, $urandom, $urandom);
        // one more to hit the full status
        send_action(opl_pkg::ACT_APPEND, pick_value(), pick_value(),
                    $urandom, $urandom, $urandom);
    endtask

    // result checker
    always @(posedge clk) begin
        opl_pkg::t_result got;
        opl_pkg::t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status      = opl_pkg::t_status'(m_tuser[1:0]);
            got.has_pair    = m_tuser[2];
            got.found_index = m_tdata[3:0];
            got.pair_first  = m_tdata[35:4];
            got.pair_second = m_tdata[67:36];
            got.entries_now = m_tdata[72:68];
            got.last        = m_tlast;
            results_seen++;
            if (got.has_pair) pairs_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("%0t: unexpected result st=%0d pair=%h/%h n=%0d", $realtime,
                             got.status, got.pair_first, got.pair_second, got.entries_now);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= MAX_SHOWN) begin
                        $display({"%0t: result %0d expected st=%0d idx=%0d pair=%h/%h",
                                  " has=%b last=%b n=%0d"},
                                 $realtime, results_seen, want.status, want.found_index,
                                 want.pair_first, want.pair_second, want.has_pair,
                                 want.last, want.entries_now);
                        $display("    got st=%0d idx=%0d pair=%h/%h has=%b last=%b n=%0d",
                                 got.status, got.found_index, got.pair_first,
                                 got.pair_second, got.has_pair, got.last, got.entries_now);
                    end
                end
            end
        end
    end

    initial begin
        t_step               step;
        opl_pkg::t_result    typed_res;
        int                  random_sent;
        int unsigned         w_app, r, len;
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  a, b;
        logic [POS_W-1:0]    pos, lastp;
        logic [SPAN_W-1:0]   cnt;
        random_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < $size(DIRECTED); k++) begin
            step = DIRECTED[k];
            send_action(step.act, step.first_v, step.second_v, step.pos, step.cnt,
                        step.lastp);
            if (step.typed) begin
                void'(pending_results.pop_back());
                typed_res             = bare_result(step.st, '0);
                typed_res.entries_now = step.entries;
                typed_res.last        = 1'b1;
                queue_expected(typed_res);
            end
        end

        // full list: widest listing, last index, widest span
        fill_list();
        send_action(opl_pkg::ACT_LIST_UNIQUE, pick_value(), pick_value(),
                    $urandom, $urandom, $urandom);
        send_action(opl_pkg::ACT_FIND, list_first[CAPACITY_DEF-1],
                    list_second[CAPACITY_DEF-1], $urandom, $urandom, $urandom);
        send_action(opl_pkg::ACT_REMOVE_THROUGH, pick_value(), pick_value(),
                    4'd15, $urandom, 4'd15);
        send_action(opl_pkg::ACT_APPEND, pick_value(), pick_value(),
                    $urandom, $urandom, $urandom);
        send_action(opl_pkg::ACT_REMOVE_COUNT, pick_value(), pick_value(),
                    4'd0, 5'd16, $urandom);

        while (random_sent < RANDOM_ITEMS) begin
            calm_stretch = (random_sent >= 90 && random_sent < 140);
            len   = list_len;
            w_app = (len < 4) ? 45 : (len > 12) ? 12 : 28;
            r     = $urandom_range(0, w_app + 59);
            a     = pick_value();
            b     = pick_value();
            pos   = $urandom;
            cnt   = $urandom;
            lastp = $urandom;
            if (r < 2) begin
                random_sent += CAPACITY_DEF + 1 - len;
                fill_list();
                continue;
            end
            r -= 2;
            if (r < w_app) begin
                act = opl_pkg::ACT_APPEND;
            end else begin
                r -= w_app;
                if (r < 10) act = opl_pkg::ACT_REMOVE_AT;
                else if (r < 20) act = opl_pkg::ACT_REMOVE_COUNT;
                else if (r < 30) act = opl_pkg::ACT_REMOVE_THROUGH;
                else if (r < 44) act = opl_pkg::ACT_FIND;
                else if (r < 50) act = opl_pkg::ACT_LIST_UNIQUE;
                else act = ACTION_W'($urandom_range(0, 7));
                // mostly well-formed positions, some noise left as drawn
                if (r < 44 && len > 0 && $urandom_range(0, 99) < 85) begin
                    pos = POS_W'($urandom_range(0, len - 1));
                    case (act)
                        opl_pkg::ACT_REMOVE_COUNT:
                            cnt = SPAN_W'($urandom_range(0, len - pos));
                        opl_pkg::ACT_REMOVE_THROUGH:
                            lastp = POS_W'($urandom_range(pos, len - 1));
                        opl_pkg::ACT_FIND: begin
                            a = list_first[pos];
                            b = list_second[pos];
                        end
                        default: ;
                    endcase
                end
            end
            send_action(act, a, b, pos, cnt, lastp);
            random_sent++;
        end
        calm_stretch = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d actions (%0d from the table), %0d results, %0d pairs emitted",
                 actions_sent, $size(DIRECTED), results_seen, pairs_seen);
        $display("full-list appends: %0d, failures: %0d", full_hits, failures);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("Verification failed");
        $finish;
    end

endmodule
